@@ rtl/mtg_pkg.sv @@
// ----------------------------------------------------------------------------
// mtg_pkg: shared constants and types of the MT19937 generator
// Holds the recurrence constants and the command/status bundles that join
// the controller and the datapath.
// ----------------------------------------------------------------------------
package mtg_pkg;

    localparam int STATE_WORDS   = 624;
    localparam int MIDDLE_OFFSET = 397;
    localparam int WORD_W        = 32;
    localparam int IDX_W         = $clog2(STATE_WORDS);

    localparam logic [WORD_W-1:0] SEED_MULT    = 32'd1812433253;
    localparam logic [WORD_W-1:0] DEFAULT_SEED = 32'd5489;
    localparam logic [WORD_W-1:0] TWIST_MATRIX = 32'h9908_B0DF;
    localparam logic [WORD_W-1:0] TEMPER_B     = 32'h9D2C_5680;
    localparam logic [WORD_W-1:0] TEMPER_C     = 32'hEFC6_0000;

    localparam logic [0:0] KIND_DRAW   = 1'b0;
    localparam logic [0:0] KIND_RESEED = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic seed_load;    // write word 0 from the seed, start the fill
        logic use_default;  // seed_load takes the default seed
        logic seed_step;    // write one recurrence word
        logic rd_pair;      // read words k and k+1
        logic rd_mid;       // latch the mixed pair, read the middle word
        logic write_out;    // write twisted word k, load the output word
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic seed_last;    // fill is at the last word
    } t_dp_sts;

endpackage

@@ rtl/mersenne_twister_generator_core.sv @@
// ----------------------------------------------------------------------------
// mersenne_twister_generator_core: MT19937 32-bit pseudo-random generator
// Draw and reseed transactions in, tempered random words out.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries i_kind and i_seed_value.
//   A reseed transaction (kind 1) fills the 624-word state memory from
//   i_seed_value and returns nothing. A draw transaction (kind 0) returns one
//   word on the output channel (o_out_valid / i_out_stall, o_random_word).
//   Timing:
//   - Draw: accept, read k and k+1, read the middle word, write back and
//     temper; the word is valid the cycle after.
//     The steps come from the single write port of the state memory and the
//     dependent middle-word read. Each draw twists its own word in place.
//   - Reseed: one recurrence word per cycle through the 32x32 multiplier.
//   - First draw after reset with no reseed: seeds with 5489 first, which
//     runs the whole fill ahead of that draw.
//   Reset clears the control state only; the memory is written by seeding
//   before it is ever read. A new transaction is taken while a finished word
//   waits; if the receiver stalls, the next draw holds at its write-back step
//   until the output register frees up.
// ----------------------------------------------------------------------------
module mersenne_twister_generator_core
    import mtg_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input channel
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [0:0]        i_kind,
    input  logic [WORD_W-1:0] i_seed_value,
    // output channel
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [WORD_W-1:0] o_random_word
);

    // Command and status bundles between sequencer and datapath.
    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    // Sequencer: owns both handshakes and the seeded flag.
    mtg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_kind      (i_kind),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (dp_sts),
        .o_cmd       (dp_cmd)
    );

    // Datapath: state memory, seed recurrence, twist and temper.
    mtg_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .i_seed_value  (i_seed_value),
        .o_sts         (dp_sts),
        .o_random_word (o_random_word)
    );

endmodule

@@ rtl/mtg_ram.sv @@
// ----------------------------------------------------------------------------
// mtg_ram: generic single-write, dual-read RAM
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module mtg_ram #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 624,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    input  logic [ADDR_W-1:0] i_rd_addr_a,
    input  logic [ADDR_W-1:0] i_rd_addr_b,
    output logic [DATA_W-1:0] o_rd_data_a,
    output logic [DATA_W-1:0] o_rd_data_b
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data_a;
    logic [DATA_W-1:0] r_rd_data_b;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data_a <= r_mem[i_rd_addr_a];
        r_rd_data_b <= r_mem[i_rd_addr_b];
    end

    assign o_rd_data_a = r_rd_data_a;
    assign o_rd_data_b = r_rd_data_b;

endmodule

@@ rtl/mtg_datapath.sv @@
// ----------------------------------------------------------------------------
// mtg_datapath: state memory, seed recurrence, twist and tempering
// Twists one word per draw in place; the fill writes one word per cycle.
// ----------------------------------------------------------------------------
module mtg_datapath
    import mtg_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    input  logic [WORD_W-1:0] i_seed_value,
    output t_dp_sts           o_sts,
    output logic [WORD_W-1:0] o_random_word
);

    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(STATE_WORDS - 1);
    localparam logic [IDX_W-1:0] MID_FWD   = IDX_W'(MIDDLE_OFFSET);
    localparam logic [IDX_W-1:0] MID_BACK  = IDX_W'(STATE_WORDS - MIDDLE_OFFSET);

    function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] y;
        y = w ^ (w >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

    logic [IDX_W-1:0]  r_index, n_index;
    logic [WORD_W-1:0] r_prev;
    logic [WORD_W-1:0] r_mixed;
    logic [WORD_W-1:0] r_out_word;

    logic [IDX_W-1:0]  idx_next;
    logic [IDX_W-1:0]  idx_mid;
    logic [WORD_W-1:0] seed_word;
    logic [WORD_W-1:0] fill_word;
    logic [WORD_W-1:0] joined;
    logic [WORD_W-1:0] mixed;
    logic [WORD_W-1:0] twisted;

    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [WORD_W-1:0] wr_data;
    logic [IDX_W-1:0]  rd_addr_a;
    logic [WORD_W-1:0] rd_data_a;
    logic [WORD_W-1:0] rd_data_b;

    assign idx_next = (r_index == LAST_IDX) ? '0 : r_index + 1'b1;
    assign idx_mid  = (r_index >= MID_BACK) ? r_index - MID_BACK : r_index + MID_FWD;

    assign seed_word = i_cmd.use_default ? DEFAULT_SEED : i_seed_value;
    assign fill_word = SEED_MULT * (r_prev ^ (r_prev >> 30))
                     + {{(WORD_W-IDX_W){1'b0}}, r_index};

    assign joined  = {rd_data_a[WORD_W-1], rd_data_b[WORD_W-2:0]};
    assign mixed   = (joined >> 1) ^ (joined[0] ? TWIST_MATRIX : '0);
    assign twisted = rd_data_a ^ r_mixed;

    assign wr_en     = i_cmd.seed_load | i_cmd.seed_step | i_cmd.write_out;
    assign wr_addr   = i_cmd.seed_load ? '0 : r_index;
    assign rd_addr_a = i_cmd.rd_pair ? r_index : idx_mid;

    always_comb begin
        wr_data = twisted;
        if (i_cmd.seed_load) begin
            wr_data = seed_word;
        end else if (i_cmd.seed_step) begin
            wr_data = fill_word;
        end
    end

    always_comb begin
        n_index = r_index;
        if (i_cmd.seed_load) begin
            n_index = IDX_W'(1);
        end else if (i_cmd.seed_step || i_cmd.write_out) begin
            n_index = idx_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index <= '0;
        end else begin
            r_index <= n_index;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.seed_load) begin
            r_prev <= seed_word;
        end else if (i_cmd.seed_step) begin
            r_prev <= fill_word;
        end
        if (i_cmd.rd_mid) begin
            r_mixed <= mixed;
        end
        if (i_cmd.write_out) begin
            r_out_word <= temper(twisted);
        end
    end

    mtg_ram #(
        .DATA_W (WORD_W),
        .DEPTH  (STATE_WORDS)
    ) u_state_ram (
        .i_clk       (i_clk),
        .i_wr_en     (wr_en),
        .i_wr_addr   (wr_addr),
        .i_wr_data   (wr_data),
        .i_rd_addr_a (rd_addr_a),
        .i_rd_addr_b (idx_next),
        .o_rd_data_a (rd_data_a),
        .o_rd_data_b (rd_data_b)
    );

    assign o_sts.seed_last = (r_index == LAST_IDX);
    assign o_random_word   = r_out_word;

endmodule

@@ rtl/mtg_ctrl.sv @@
// ----------------------------------------------------------------------------
// mtg_ctrl: sequencer of the MT19937 generator
// Runs the seed fill and the three-step draw, and owns both handshakes.
// ----------------------------------------------------------------------------
module mtg_ctrl
    import mtg_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [0:0] i_kind,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    input  t_dp_sts    i_sts,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEED,
        S_RD_PAIR,
        S_RD_MID,
        S_WRITE
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   r_seeded;
    logic   r_draw_pending;

    logic in_accept;
    logic out_accept;
    logic fire;

    assign in_accept  = i_in_valid && (r_state == S_IDLE);
    assign out_accept = r_out_valid && !i_out_stall;
    assign fire       = (r_state == S_WRITE) && (!r_out_valid || !i_out_stall);

    always_comb begin
        o_cmd             = '0;
        o_cmd.seed_load   = in_accept && (i_kind == KIND_RESEED || !r_seeded);
        o_cmd.use_default = (i_kind == KIND_DRAW);
        o_cmd.seed_step   = (r_state == S_SEED);
        o_cmd.rd_pair     = (r_state == S_RD_PAIR);
        o_cmd.rd_mid      = (r_state == S_RD_MID);
        o_cmd.write_out   = fire;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_out_valid    <= 1'b0;
            r_seeded       <= 1'b0;
            r_draw_pending <= 1'b0;
        end else begin
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (out_accept) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        if (i_kind == KIND_RESEED) begin
                            r_state        <= S_SEED;
                            r_seeded       <= 1'b1;
                            r_draw_pending <= 1'b0;
                        end else if (!r_seeded) begin
                            r_state        <= S_SEED;
                            r_seeded       <= 1'b1;
                            r_draw_pending <= 1'b1;
                        end else begin
                            r_state <= S_RD_PAIR;
                        end
                    end
                end
                S_SEED: begin
                    if (i_sts.seed_last) begin
                        r_state        <= r_draw_pending ? S_RD_PAIR : S_IDLE;
                        r_draw_pending <= 1'b0;
                    end
                end
                S_RD_PAIR: r_state <= S_RD_MID;
                S_RD_MID:  r_state <= S_WRITE;
                S_WRITE: begin
                    if (fire) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

@@ rtl/mtg_checker.sv @@
// ----------------------------------------------------------------------------
// mtg_checker: port-level checks of the MT19937 generator
// Watches the two channels of the top level over time.
// ----------------------------------------------------------------------------
module mtg_checker
    import mtg_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input logic [0:0]        i_kind,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input logic [WORD_W-1:0] o_random_word
);

    logic in_accept;
    assign in_accept = i_in_valid && !o_in_stall;

    // A stalled word holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_random_word))
        else $error("output word changed under stall");

    // The block is busy in the cycle after every accepted transaction.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> o_in_stall)
        else $error("input taken again right after a transaction");

    // A reseed produces no word.
    a_reseed_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && (i_kind == KIND_RESEED) && !o_out_valid |=> !o_out_valid)
        else $error("reseed produced an output word");

    // A new word only appears after a busy cycle.
    a_word_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("output word appeared without work");

endmodule

bind mersenne_twister_generator_core mtg_checker u_mtg_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_stall    (o_in_stall),
    .i_kind        (i_kind),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_random_word (o_random_word)
);
